// File: src/stereo_ping_pong_delay_unit_macros.svh
// assertion macros shared by the delay unit modules
// no dependencies; included by files that carry concurrent checks
`ifndef STEREO_PING_PONG_DELAY_UNIT_MACROS_SVH
`define STEREO_PING_PONG_DELAY_UNIT_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define SPPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sppd assertion failed");

// next-cycle implication under asynchronous active-low reset
`define SPPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sppd assertion failed");

`endif

// File: src/sppd_pkg.sv
// shared types and constants of the stereo ping-pong delay unit
// no dependencies; used by the config block, the core and the top level
package sppd_pkg;

	localparam int APB_AW = 4;
	localparam int GAIN_W = 15;
	localparam int SAMPLE_W = 18;
	localparam int WET_W = 19;
	localparam int OUT_W = 16;

	localparam logic [GAIN_W-1:0] RST_DELAY_LENGTH = 15'd10560;
	localparam logic [GAIN_W-1:0] RST_CROSS_GAIN = 15'd10813;
	localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 15'd29491;
	localparam logic [GAIN_W-1:0] RST_CLIP_LEVEL = 15'd31130;

	typedef enum logic [1:0] {
		REG_DELAY_LENGTH,
		REG_CROSS_GAIN,
		REG_FEEDBACK_GAIN,
		REG_CLIP_LEVEL
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] delay_length;
		logic [GAIN_W-1:0] cross_gain;
		logic [GAIN_W-1:0] feedback_gain;
		logic [GAIN_W-1:0] clip_level;
	} cfg_t;

endpackage

// File: src/sppd_stream_if.sv
// valid/ready stream interfaces for dry input pairs and wet output pairs
// depends on nothing but the sample widths written below
interface sppd_in_if;
	logic valid;
	logic ready;
	logic signed [17:0] dry_left;
	logic signed [17:0] dry_right;

	modport source(output valid, output dry_left, output dry_right, input ready);
	modport sink(input valid, input dry_left, input dry_right, output ready);
endinterface

interface sppd_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] wet_left;
	logic signed [15:0] wet_right;

	modport source(output valid, output wet_left, output wet_right, input ready);
	modport sink(input valid, input wet_left, input wet_right, output ready);
endinterface

// File: src/sppd_mem.sv
// simple dual-port memory, one write and one registered read per cycle
// no dependencies; holds the stereo echo store
module sppd_mem #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/sppd_cfg.sv
// register file behind the apb-style configuration port
// depends on sppd_pkg for the register map and the config struct
module sppd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sppd_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output sppd_pkg::cfg_t               cfg
);

	sppd_pkg::cfg_t   cfg_q;
	sppd_pkg::reg_idx_t idx;
	logic             wr_stb;

	assign pready = 1'b1;
	assign idx = sppd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_stb = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_length <= sppd_pkg::RST_DELAY_LENGTH;
			cfg_q.cross_gain <= sppd_pkg::RST_CROSS_GAIN;
			cfg_q.feedback_gain <= sppd_pkg::RST_FEEDBACK_GAIN;
			cfg_q.clip_level <= sppd_pkg::RST_CLIP_LEVEL;
		end else if (wr_stb) begin
			case (idx)
				sppd_pkg::REG_DELAY_LENGTH: cfg_q.delay_length <= pwdata[14:0];
				sppd_pkg::REG_CROSS_GAIN: cfg_q.cross_gain <= pwdata[14:0];
				sppd_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= pwdata[14:0];
				sppd_pkg::REG_CLIP_LEVEL: cfg_q.clip_level <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sppd_pkg::REG_DELAY_LENGTH: prdata = {17'd0, cfg_q.delay_length};
			sppd_pkg::REG_CROSS_GAIN: prdata = {17'd0, cfg_q.cross_gain};
			sppd_pkg::REG_FEEDBACK_GAIN: prdata = {17'd0, cfg_q.feedback_gain};
			sppd_pkg::REG_CLIP_LEVEL: prdata = {17'd0, cfg_q.clip_level};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: src/sppd_core.sv
// read-modify-write pipeline around the echo store, pointer and output register
// depends on sppd_pkg, sppd_stream_if, sppd_mem and the assertion macros
`include "stereo_ping_pong_delay_unit_macros.svh"

module sppd_core #(
	parameter int MAX_DELAY_DEPTH = 16384
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sppd_pkg::cfg_t cfg,
	sppd_in_if.sink        in_ch,
	sppd_out_if.source     out_ch
);

	localparam int AW = $clog2(MAX_DELAY_DEPTH);
	localparam int CW = (AW + 1 > 16) ? AW + 1 : 16;
	localparam int SW = sppd_pkg::SAMPLE_W;
	localparam int WW = sppd_pkg::WET_W;
	localparam int OW = sppd_pkg::OUT_W;

	// pointer and fill count: written entries always form the prefix below fill_q
	logic [AW-1:0] pos_q;
	logic [AW:0]   fill_q;
	logic [AW:0]   pos_inc;
	logic          wrap;
	logic [AW-1:0] pos_next;
	logic [AW:0]   fill_next;
	logic [AW-1:0] pos_now;
	logic [AW:0]   fill_now;

	logic in_xfer;
	logic s1_valid;
	logic s2_valid;
	logic s2_done;
	logic out_valid_q;

	logic signed [SW-1:0] dry_l_s1;
	logic signed [SW-1:0] dry_r_s1;
	logic                 zero_s1;
	logic                 fwd_s1;
	logic [2*SW-1:0]      fwd_data_s1;

	logic [2*SW-1:0] rd_data;
	logic [2*SW-1:0] wr_data;
	logic [2*SW-1:0] echo;

	logic signed [SW-1:0]   echo_l;
	logic signed [SW-1:0]   echo_r;
	logic signed [SW+15:0]  xprod_l;
	logic signed [SW+15:0]  xprod_r;
	logic signed [SW+15:0]  xrnd_l;
	logic signed [SW+15:0]  xrnd_r;
	logic signed [WW-1:0]   wet_l;
	logic signed [WW-1:0]   wet_r;
	logic signed [WW-1:0]   wet_l_s2;
	logic signed [WW-1:0]   wet_r_s2;

	logic signed [WW+15:0]  fprod_l;
	logic signed [WW+15:0]  fprod_r;
	logic signed [WW+15:0]  frnd_l;
	logic signed [WW+15:0]  frnd_r;
	logic signed [SW-1:0]   sat_l;
	logic signed [SW-1:0]   sat_r;

	logic signed [WW-1:0]   lim;
	logic signed [OW-1:0]   clip_l;
	logic signed [OW-1:0]   clip_r;
	logic signed [OW-1:0]   wet_l_q;
	logic signed [OW-1:0]   wet_r_q;

	assign s2_done = s2_valid && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid && (!s2_valid || s2_done);
	assign in_xfer = in_ch.valid && in_ch.ready;

	// a zero length wraps like one, an oversized one like the full depth
	assign pos_inc = {1'b0, pos_q} + {{AW{1'b0}}, 1'b1};
	assign wrap = (CW'(pos_inc) >= CW'(cfg.delay_length))
		|| (CW'(pos_inc) >= CW'(MAX_DELAY_DEPTH));
	assign pos_next = wrap ? '0 : pos_inc[AW-1:0];
	assign fill_next = (fill_q == {1'b0, pos_q}) ? fill_q + {{AW{1'b0}}, 1'b1} : fill_q;
	assign pos_now = s2_done ? pos_next : pos_q;
	assign fill_now = s2_done ? fill_next : fill_q;

	sppd_mem #(
		.DEPTH(MAX_DELAY_DEPTH),
		.WIDTH(2 * SW)
	) u_mem (
		.clk(clk),
		.wr_en(s2_done),
		.wr_addr(pos_q),
		.wr_data(wr_data),
		.rd_en(in_xfer),
		.rd_addr(pos_now),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_done) begin
				pos_q <= pos_next;
				fill_q <= fill_next;
			end
			s1_valid <= in_xfer;
			s2_valid <= s1_valid || (s2_valid && !s2_done);
			if (s2_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 capture at the input transfer; forward the entry being written back
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dry_l_s1 <= in_ch.dry_left;
			dry_r_s1 <= in_ch.dry_right;
			zero_s1 <= ({1'b0, pos_now} == fill_now);
			fwd_s1 <= s2_done && (pos_now == pos_q);
			fwd_data_s1 <= wr_data;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			echo = fwd_data_s1;
		end else if (zero_s1) begin
			echo = '0;
		end else begin
			echo = rd_data;
		end
	end

	assign echo_l = echo[2*SW-1:SW];
	assign echo_r = echo[SW-1:0];

	// cross-channel echo, rounded half up to q2.15
	assign xprod_l = (SW+16)'(echo_r) * (SW+16)'($signed({1'b0, cfg.cross_gain}));
	assign xprod_r = (SW+16)'(echo_l) * (SW+16)'($signed({1'b0, cfg.cross_gain}));
	assign xrnd_l = (xprod_l + (SW+16)'(16384)) >>> 15;
	assign xrnd_r = (xprod_r + (SW+16)'(16384)) >>> 15;
	assign wet_l = {dry_l_s1[SW-1], dry_l_s1} + xrnd_l[WW-1:0];
	assign wet_r = {dry_r_s1[SW-1], dry_r_s1} + xrnd_r[WW-1:0];

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			wet_l_s2 <= wet_l;
			wet_r_s2 <= wet_r;
		end
	end

	// feedback path, saturated to the store width
	assign fprod_l = (WW+16)'(wet_l_s2) * (WW+16)'($signed({1'b0, cfg.feedback_gain}));
	assign fprod_r = (WW+16)'(wet_r_s2) * (WW+16)'($signed({1'b0, cfg.feedback_gain}));
	assign frnd_l = (fprod_l + (WW+16)'(16384)) >>> 15;
	assign frnd_r = (fprod_r + (WW+16)'(16384)) >>> 15;

	always_comb begin
		if (frnd_l > (WW+16)'(131071)) begin
			sat_l = SW'(131071);
		end else if (frnd_l < -(WW+16)'(131072)) begin
			sat_l = SW'(-131072);
		end else begin
			sat_l = frnd_l[SW-1:0];
		end
		if (frnd_r > (WW+16)'(131071)) begin
			sat_r = SW'(131071);
		end else if (frnd_r < -(WW+16)'(131072)) begin
			sat_r = SW'(-131072);
		end else begin
			sat_r = frnd_r[SW-1:0];
		end
	end

	assign wr_data = {sat_l, sat_r};

	// symmetric output clip
	assign lim = $signed({{(WW-15){1'b0}}, cfg.clip_level});

	always_comb begin
		if (wet_l_s2 > lim) begin
			clip_l = lim[OW-1:0];
		end else if (wet_l_s2 < -lim) begin
			clip_l = -lim[OW-1:0];
		end else begin
			clip_l = wet_l_s2[OW-1:0];
		end
		if (wet_r_s2 > lim) begin
			clip_r = lim[OW-1:0];
		end else if (wet_r_s2 < -lim) begin
			clip_r = -lim[OW-1:0];
		end else begin
			clip_r = wet_r_s2[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			wet_l_q <= clip_l;
			wet_r_q <= clip_r;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.wet_left = wet_l_q;
	assign out_ch.wet_right = wet_r_q;

	`SPPD_ASSERT_IMP(a_one_item_in_flight, clk, arst_n, s1_valid, !s2_valid)
	`SPPD_ASSERT_IMP(a_pos_within_prefix, clk, arst_n, 1'b1, {1'b0, pos_q} <= fill_q)
	`SPPD_ASSERT_NEXT(a_writeback_gives_result, clk, arst_n, s2_done, out_valid_q)
	`SPPD_ASSERT_NEXT(a_transfer_starts_read, clk, arst_n, in_xfer, s1_valid && !s2_valid)

endmodule

// File: src/stereo_ping_pong_delay_unit.sv
// top level of the stereo ping-pong delay unit
// depends on sppd_pkg, sppd_stream_if, sppd_cfg and sppd_core
//
// One stereo dry pair in, one clipped wet pair out. A pair is read from the echo store
// at its transfer, mixed with the cross gain in the next cycle and written back through
// the feedback gain once the output register can take it, while the next pair's read
// is issued; so a new pair is not taken before the last one's write-back, and a result
// is loaded into the output register at that write-back. The store needs no clearing
// pass after reset: a fill count marks the entries written so far and everything beyond
// it reads as zero. The output register holds a waiting result while the next pair is
// read; a stalled output holds the pipeline only at write-back.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 and should be written
// while no pair is in flight.
module stereo_ping_pong_delay_unit #(
	parameter int MAX_DELAY_DEPTH = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sppd_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	sppd_in_if.sink                     in_ch,
	sppd_out_if.source                  out_ch
);

	sppd_pkg::cfg_t cfg;

	sppd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	sppd_core #(
		.MAX_DELAY_DEPTH(MAX_DELAY_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

endmodule

// File: test/testbench.sv
// self-checking testbench for the stereo ping-pong delay unit
// depends on sppd_pkg, sppd_stream_if and stereo_ping_pong_delay_unit
// directed table first, then random phases checked against a bit-true echo predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sppd_pkg::*;

	localparam int MAX_DELAY_DEPTH = 16384;
	localparam int PHASES = 12;
	localparam int PHASE_PAIRS = 120;

	typedef struct packed {
		logic signed [15:0] wet_l;
		logic signed [15:0] wet_r;
	} wet_pair_t;

	typedef struct packed {
		logic               is_cfg;
		reg_idx_t           idx;
		logic [31:0]        value;
		logic signed [17:0] dl;
		logic signed [17:0] dr;
		logic               typed;
		logic signed [15:0] el;
		logic signed [15:0] er;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sppd_in_if  in_bus();
	sppd_out_if out_bus();

	stereo_ping_pong_delay_unit #(
		.MAX_DELAY_DEPTH(MAX_DELAY_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(in_bus),
		.out_ch(out_bus)
	);

	// predictor state
	logic signed [17:0] echo_left [MAX_DELAY_DEPTH];
	logic signed [17:0] echo_right [MAX_DELAY_DEPTH];
	int unsigned        echo_pos;
	cfg_t               cfg_mirror;

	wet_pair_t   wet_due[$];
	int unsigned mismatches;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [17:0] pick_dry();
		logic [31:0] r;
		int          v;
		r = $urandom();
		v = int'($urandom_range(0, 4000)) - 2000;
		case ($urandom_range(0, 9))
			0: return 18'sh1FFFF;
			1: return 18'sh20000;
			2, 3: return v[17:0];
			default: return r[17:0];
		endcase
	endfunction

	// q2.15 times q0.15, rounded half up back to q2.15
	function automatic longint scale_q15(longint x, logic [GAIN_W-1:0] g);
		return (x * longint'(g) + 64'sd16384) >>> 15;
	endfunction

	function automatic logic signed [17:0] sat_store(longint v);
		if (v > 131071)
			v = 131071;
		else if (v < -131072)
			v = -131072;
		return v[17:0];
	endfunction

	function automatic logic signed [15:0] clip_out(longint v, logic [GAIN_W-1:0] lim);
		longint l;
		l = longint'(lim);
		if (v > l)
			v = l;
		else if (v < -l)
			v = -l;
		return v[15:0];
	endfunction

	function automatic wet_pair_t predict_echo(logic signed [17:0] dl, logic signed [17:0] dr);
		int unsigned len;
		int unsigned pos;
		longint      wl;
		longint      wr;
		wet_pair_t   res;
		len = 32'(cfg_mirror.delay_length);
		if (len < 1)
			len = 1;
		if (len > MAX_DELAY_DEPTH)
			len = MAX_DELAY_DEPTH;
		pos = echo_pos;
		if (pos >= MAX_DELAY_DEPTH)
			pos = 0;
		// each side hears the opposite side's echo
		wl = longint'(dl) + scale_q15(longint'(echo_right[pos]), cfg_mirror.cross_gain);
		wr = longint'(dr) + scale_q15(longint'(echo_left[pos]), cfg_mirror.cross_gain);
		echo_left[pos] = sat_store(scale_q15(wl, cfg_mirror.feedback_gain));
		echo_right[pos] = sat_store(scale_q15(wr, cfg_mirror.feedback_gain));
		pos++;
		if (pos >= len)
			pos = 0;
		echo_pos = pos;
		res.wet_l = clip_out(wl, cfg_mirror.clip_level);
		res.wet_r = clip_out(wr, cfg_mirror.clip_level);
		return res;
	endfunction

	// drives one pair and returns the predicted wet pair at its transfer
	task automatic send_pair(input logic signed [17:0] dl, input logic signed [17:0] dr,
			output wet_pair_t predicted);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.dry_left <= dl;
		in_bus.dry_right <= dr;
		do @(posedge clk); while (!in_bus.ready);
		predicted = predict_echo(dl, dr);
	endtask

	task automatic wait_results();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (wet_due.size() != 0);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== {17'd0, cfg_mirror[(3 - idx) * GAIN_W +: GAIN_W]}) begin
			$error("prdata: expected %0d, got %0d",
				cfg_mirror[(3 - idx) * GAIN_W +: GAIN_W], prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with nothing in flight
	task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
		wait_results();
		repeat (8) @(posedge clk);
		apb_access(1'b1, idx, value);
		case (idx)
			REG_DELAY_LENGTH: cfg_mirror.delay_length = value[GAIN_W-1:0];
			REG_CROSS_GAIN: cfg_mirror.cross_gain = value[GAIN_W-1:0];
			REG_FEEDBACK_GAIN: cfg_mirror.feedback_gain = value[GAIN_W-1:0];
			default: cfg_mirror.clip_level = value[GAIN_W-1:0];
		endcase
		apb_access(1'b0, idx, 32'd0);
	endtask

	task automatic set_random_bits(input reg_idx_t idx, input logic [GAIN_W-1:0] v);
		logic [31:0] r;
		r = $urandom();
		r[GAIN_W-1:0] = v;
		set_register(idx, r);
	endtask

	function automatic plan_row_t pair_row(int dl, int dr);
		return '{1'b0, REG_DELAY_LENGTH, 32'd0, dl[17:0], dr[17:0], 1'b0, 16'sd0, 16'sd0};
	endfunction

	function automatic plan_row_t known_row(int dl, int dr, int el, int er);
		return '{1'b0, REG_DELAY_LENGTH, 32'd0, dl[17:0], dr[17:0], 1'b1, el[15:0], er[15:0]};
	endfunction

	function automatic plan_row_t cfg_row(reg_idx_t idx, logic [31:0] value);
		return '{1'b1, idx, value, 18'sd0, 18'sd0, 1'b0, 16'sd0, 16'sd0};
	endfunction

	// result checker and output stall generator
	initial begin
		int unsigned stall;
		wet_pair_t   want;
		stall = 0;
		out_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				if (wet_due.size() == 0) begin
					$error("wet pair transfer with nothing expected: %0d %0d",
						out_bus.wet_left, out_bus.wet_right);
					mismatches++;
				end else begin
					want = wet_due.pop_front();
					if (out_bus.wet_left !== want.wet_l) begin
						$error("wet_left: expected %0d, got %0d", want.wet_l, out_bus.wet_left);
						mismatches++;
					end
					if (out_bus.wet_right !== want.wet_r) begin
						$error("wet_right: expected %0d, got %0d", want.wet_r,
							out_bus.wet_right);
						mismatches++;
					end
				end
			end
			if (stall != 0) begin
				stall--;
				out_bus.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				if (stall != 0) begin
					stall--;
					out_bus.ready <= 1'b0;
				end else begin
					out_bus.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		plan_row_t   plan[$];
		wet_pair_t   got;
		logic [GAIN_W-1:0] d;
		logic [GAIN_W-1:0] c;
		logic [GAIN_W-1:0] f;
		logic [GAIN_W-1:0] k;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.dry_left = '0;
		in_bus.dry_right = '0;
		mismatches = 0;
		calm = 1'b0;
		echo_pos = 0;
		for (int i = 0; i < MAX_DELAY_DEPTH; i++) begin
			echo_left[i] = '0;
			echo_right[i] = '0;
		end
		cfg_mirror.delay_length = RST_DELAY_LENGTH;
		cfg_mirror.cross_gain = RST_CROSS_GAIN;
		cfg_mirror.feedback_gain = RST_FEEDBACK_GAIN;
		cfg_mirror.clip_level = RST_CLIP_LEVEL;

		// empty store: wet equals dry, then clipped
		plan.push_back(known_row(0, 0, 0, 0));
		plan.push_back(known_row(131071, -131072, 31130, -31130));
		plan.push_back(known_row(-1, 1, -1, 1));
		plan.push_back(cfg_row(REG_CLIP_LEVEL, 32'd0));
		plan.push_back(known_row(5000, -7000, 0, 0));
		// junk above bit 14 must be dropped
		plan.push_back(cfg_row(REG_CLIP_LEVEL, 32'hABCD_7FFF));
		plan.push_back(known_row(32767, -32767, 32767, -32767));
		plan.push_back(known_row(-131072, 131071, -32767, 32767));
		plan.push_back(known_row(32768, -32768, 32767, -32767));
		// zero length acts as one, and the position lies past it
		plan.push_back(cfg_row(REG_DELAY_LENGTH, 32'd0));
		plan.push_back(cfg_row(REG_CROSS_GAIN, 32'd32767));
		plan.push_back(cfg_row(REG_FEEDBACK_GAIN, 32'd32767));
		// full-scale loop drives the write-back into saturation
		repeat (3) plan.push_back(pair_row(131071, 131071));
		repeat (3) plan.push_back(pair_row(-131072, -131072));
		plan.push_back(cfg_row(REG_DELAY_LENGTH, 32'hFFFF_8003));
		plan.push_back(pair_row(1000, -2000));
		plan.push_back(pair_row(-3000, 4000));
		plan.push_back(pair_row(5, -5));
		plan.push_back(pair_row(0, 0));
		// above the store depth acts as the full depth
		plan.push_back(cfg_row(REG_DELAY_LENGTH, 32'd32767));
		plan.push_back(pair_row(77777, -88888));
		plan.push_back(pair_row(-1, -1));
		plan.push_back(cfg_row(REG_DELAY_LENGTH, 32'd16384));
		plan.push_back(pair_row(12345, -54321));
		plan.push_back(cfg_row(REG_CROSS_GAIN, 32'd0));
		plan.push_back(pair_row(-131072, 131071));
		plan.push_back(cfg_row(REG_FEEDBACK_GAIN, 32'd0));
		plan.push_back(pair_row(2, -3));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_register(plan[i].idx, plan[i].value);
			end else begin
				send_pair(plan[i].dl, plan[i].dr, got);
				if (plan[i].typed)
					wet_due.push_back('{plan[i].el, plan[i].er});
				else
					wet_due.push_back(got);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			c = GAIN_W'($urandom_range(0, 32767));
			f = GAIN_W'($urandom_range(0, 32767));
			k = GAIN_W'(($urandom_range(0, 1) != 0) ? $urandom_range(24000, 32767) :
				$urandom_range(0, 32767));
			d = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(65, 400) :
				$urandom_range(1, 64));
			case (phase)
				0: begin
					d = GAIN_W'(1);
					c = GAIN_W'(32767);
					f = GAIN_W'(32767);
					k = GAIN_W'(32767);
				end
				1: begin
					d = GAIN_W'(2);
					c = '0;
					f = '0;
					k = '0;
				end
				2: d = GAIN_W'(32767);
				3: d = '0;
				default: ;
			endcase
			set_random_bits(REG_DELAY_LENGTH, d);
			set_random_bits(REG_CROSS_GAIN, c);
			set_random_bits(REG_FEEDBACK_GAIN, f);
			set_random_bits(REG_CLIP_LEVEL, k);
			calm = (phase % 4 == 3);
			for (int n = 0; n < PHASE_PAIRS; n++) begin
				// sender holds off until the pipeline has emptied
				if (n == PHASE_PAIRS / 2 && phase == 5)
					wait_results();
				send_pair(pick_dry(), pick_dry(), got);
				wet_due.push_back(got);
			end
		end

		calm = 1'b0;
		wait_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/sppd_pkg.sv
src/sppd_stream_if.sv
src/sppd_mem.sv
src/sppd_cfg.sv
src/sppd_core.sv
src/stereo_ping_pong_delay_unit.sv
test/testbench.sv
